/* design/rts_pkg.sv */
// ----------------------------------------------------------------------------
// rts_pkg
// Shared constants and types for the record table sorter.
// ----------------------------------------------------------------------------
package rts_pkg;
	localparam int MaxRecords = 32;
	localparam int AddrW      = $clog2(MaxRecords);
	localparam int CountW     = $clog2(MaxRecords + 1);
	localparam int RecW       = 64 + 64 + 16 + 21 + 34;
	localparam int InDataW    = 200;
	localparam int OutDataW   = 200;

	typedef logic [AddrW-1:0]  addr_t;
	typedef logic [CountW-1:0] count_t;

	typedef struct packed {
		logic [63:0] id;
		logic [63:0] name;
		logic [15:0] gender;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [7:0]  math;
		logic [7:0]  english;
		logic [7:0]  lang;
		logic [9:0]  total;
	} rec_t;
endpackage

/* design/rts_ram.sv */
// ----------------------------------------------------------------------------
// rts_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rts_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* design/record_table_sorter_unit.sv */
// ----------------------------------------------------------------------------
// record_table_sorter_unit
// Loads records into a table RAM, sorts in place on the last beat, streams
// the sorted table out.
// ----------------------------------------------------------------------------
// channel   dir  beat
// s_axis    in   tdata = record fields, tlast = final record
// m_axis    out  tdata = record fields, tlast = last sorted record
// cfg       in   cfg_data = sort key
// Loading accepts a beat whenever s_axis_tvalid is high. Sorting reads one entry
// per cycle from the single-read RAM: name mode reads k-1, then k, then compares,
// plus a write per swap; total mode finds the highest total and swaps it to i.
// Output reads each record, then presents it, held while m_axis_tready is low.
// Reset empties the table and clears the sort key; the RAM is not cleared.
module record_table_sorter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// id, name, gender_code, birth_year, birth_month, birth_day, math, english,
	// lang, total_score (low bit up)
	input  logic [rts_pkg::InDataW-1:0]   s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_id, out_name, out_gender, out_year, out_month, out_day, out_math,
	// out_english, out_lang, out_total (low bit up)
	output logic [rts_pkg::OutDataW-1:0]  m_axis_tdata,
	output logic                          m_axis_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);
	localparam logic [3:0] StLoad  = 4'd0;
	localparam logic [3:0] StNRd0  = 4'd1;  // read k-1
	localparam logic [3:0] StNRd1  = 4'd2;  // hold k-1, read k
	localparam logic [3:0] StNCmp  = 4'd3;  // compare, maybe write k-1
	localparam logic [3:0] StNWr   = 4'd4;  // write k
	localparam logic [3:0] StTRdI  = 4'd5;
	localparam logic [3:0] StTScan = 4'd6;
	localparam logic [3:0] StTRdB  = 4'd7;
	localparam logic [3:0] StTHold = 4'd8;
	localparam logic [3:0] StTWr   = 4'd9;
	localparam logic [3:0] StORd   = 4'd10;
	localparam logic [3:0] StOut   = 4'd11;
	localparam logic [3:0] StTWr2  = 4'd12;

	logic [3:0]      state_q;
	logic            key_q;
	rts_pkg::count_t count_q;
	rts_pkg::count_t i_q, k_q, best_q;
	logic [9:0]      best_tot_q;
	rts_pkg::rec_t   hold_q, rd, wrec, in_rec;
	logic            we;
	rts_pkg::addr_t  waddr, raddr;
	logic [rts_pkg::RecW-1:0] rdata;

	assign in_rec = '{id: s_axis_tdata[63:0], name: s_axis_tdata[127:64],
		gender: s_axis_tdata[143:128], year: s_axis_tdata[155:144],
		month: s_axis_tdata[159:156], day: s_axis_tdata[164:160],
		math: s_axis_tdata[172:165], english: s_axis_tdata[180:173],
		lang: s_axis_tdata[188:181], total: s_axis_tdata[198:189]};
	assign rd = rts_pkg::rec_t'(rdata);

	assign s_axis_tready = (state_q == StLoad);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = (state_q == StOut);
	assign m_axis_tlast  = (i_q + 1'b1 == count_q);
	assign m_axis_tdata  = {1'b0, rd.total, rd.lang, rd.english, rd.math, rd.day,
		rd.month, rd.year, rd.gender, rd.name, rd.id};

	always_comb begin
		we    = 1'b0;
		waddr = k_q[rts_pkg::AddrW-1:0];
		wrec  = hold_q;
		raddr = k_q[rts_pkg::AddrW-1:0];
		unique case (state_q)
			StLoad: begin
				we    = s_axis_tvalid && (count_q != rts_pkg::CountW'(rts_pkg::MaxRecords));
				waddr = count_q[rts_pkg::AddrW-1:0];
				wrec  = in_rec;
			end
			StNRd0:  raddr = rts_pkg::AddrW'(k_q - 1'b1);
			StNRd1:  raddr = k_q[rts_pkg::AddrW-1:0];
			StNCmp: begin
				we    = rd.name < hold_q.name;
				waddr = rts_pkg::AddrW'(k_q - 1'b1);
				wrec  = rd;
			end
			StNWr:   we = 1'b1;
			StTRdI:  raddr = i_q[rts_pkg::AddrW-1:0];
			StTScan: raddr = k_q[rts_pkg::AddrW-1:0];
			StTRdB:  raddr = best_q[rts_pkg::AddrW-1:0];
			StTHold: raddr = i_q[rts_pkg::AddrW-1:0];
			StTWr: begin
				we    = 1'b1;
				waddr = i_q[rts_pkg::AddrW-1:0];
			end
			StTWr2: begin
				we    = 1'b1;
				waddr = best_q[rts_pkg::AddrW-1:0];
			end
			StORd, StOut: raddr = i_q[rts_pkg::AddrW-1:0];
			default: ;
		endcase
	end

	rts_ram #(.Width(rts_pkg::RecW), .Depth(rts_pkg::MaxRecords)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wrec), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
			key_q   <= 1'b0;
			count_q <= '0;
			i_q     <= '0;
			k_q     <= '0;
			best_q  <= '0;
		end else begin
			if (cfg_valid)
				key_q <= cfg_data;
			unique case (state_q)
				StLoad: if (s_axis_tvalid) begin
					if (we)
						count_q <= count_q + 1'b1;
					if (s_axis_tlast) begin
						i_q <= '0;
						k_q <= we ? count_q : count_q - 1'b1;
						if ((we ? count_q + 1'b1 : count_q) <= rts_pkg::CountW'(1))
							state_q <= StORd;
						else
							state_q <= key_q ? StTRdI : StNRd0;
					end
				end
				StNRd0: state_q <= StNRd1;
				StNRd1: begin
					hold_q  <= rd;
					state_q <= StNCmp;
				end
				StNCmp: begin
					if (we)
						state_q <= StNWr;
					else if (k_q - 1'b1 > i_q) begin
						k_q <= k_q - 1'b1;
						state_q <= StNRd0;
					end else if (i_q + 2'd2 < count_q) begin
						i_q <= i_q + 1'b1;
						k_q <= count_q - 1'b1;
						state_q <= StNRd0;
					end else begin
						i_q <= '0;
						state_q <= StORd;
					end
				end
				StNWr: begin
					if (k_q - 1'b1 > i_q) begin
						k_q <= k_q - 1'b1;
						state_q <= StNRd0;
					end else if (i_q + 2'd2 < count_q) begin
						i_q <= i_q + 1'b1;
						k_q <= count_q - 1'b1;
						state_q <= StNRd0;
					end else begin
						i_q <= '0;
						state_q <= StORd;
					end
				end
				StTRdI: begin
					best_q  <= i_q;
					k_q     <= i_q + 1'b1;
					state_q <= StTScan;
				end
				StTScan: begin
					// rd holds entry k-1 (or i on first cycle)
					if (k_q == i_q + 1'b1)
						best_tot_q <= rd.total;
					else if (rd.total > best_tot_q) begin
						best_tot_q <= rd.total;
						best_q     <= k_q - 1'b1;
					end
					if (k_q == count_q)
						state_q <= StTRdB;
					else
						k_q <= k_q + 1'b1;
				end
				StTRdB: begin
					state_q <= StTHold;
				end
				StTHold: begin
					// rd = best entry
					hold_q  <= rd;
					state_q <= StTWr;
				end
				StTWr: begin
					// rd = entry i, goes to the best slot next
					hold_q  <= rd;
					state_q <= StTWr2;
				end
				StTWr2: begin
					if (i_q + 2'd2 < count_q) begin
						i_q <= i_q + 1'b1;
						state_q <= StTRdI;
					end else begin
						i_q <= '0;
						state_q <= StORd;
					end
				end
				StORd: state_q <= (count_q == '0) ? StLoad : StOut;
				StOut: if (m_axis_tready) begin
					if (m_axis_tlast) begin
						count_q <= '0;
						state_q <= StLoad;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= StORd;
					end
				end
				default: state_q <= StLoad;
			endcase
		end
	end
endmodule

/* design/rts_checker.sv */
// ----------------------------------------------------------------------------
// rts_checker
// Port-level checks for the record table sorter.
// ----------------------------------------------------------------------------
module rts_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("load and output overlap");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("not back to load");
endmodule

bind record_table_sorter_unit rts_checker u_rts_checker (.*);
